>>> hw/rtl/ecm_class_nano_filter_macros.svh
// ----------------------------------------------------------------------------
// ecm_class_nano_filter_macros.svh
// Assertion macros shared by the class filter RTL.
// ----------------------------------------------------------------------------
`ifndef ECM_CLASS_NANO_FILTER_MACROS_SVH
`define ECM_CLASS_NANO_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
`define ECF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ECF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ECF_ASSERT(label, prop, msg)
`define ECF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hw/rtl/ecf_pkg.sv
// ----------------------------------------------------------------------------
// ecf_pkg
// Types and constants of the ECM class filter.
// ----------------------------------------------------------------------------
package ecf_pkg;

  localparam int MaxMsgBytesDef = 512;
  localparam int QueueDepth     = 2;
  localparam int NumMaps        = 4;
  localparam int MapW           = 64;
  localparam int ClassW         = 8;
  localparam int CountW         = 8;
  localparam int CfgIdxW        = 3;

  localparam logic [7:0]  TagClass    = 8'hE2;
  localparam logic [7:0]  MarkTps     = 8'hD2;
  localparam logic [7:0]  MarkStop    = 8'hEA;
  localparam logic [15:0] SysFiltered = 16'h0500;
  localparam int          StartTps    = 12;
  localparam int          StartPlain  = 9;
  localparam int          TpsMarkPos  = 4;

  localparam logic [CfgIdxW-1:0] CfgAllowedBase = 3'd4;

  typedef enum logic [1:0] {
    VC_OK         = 2'd0,
    VC_NA         = 2'd1,
    VC_BLOCKED    = 2'd2,
    VC_NO_ALLOWED = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] system_id;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic              pass;
    logic [1:0]        verdict_code;
    logic [CountW-1:0] class_count;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic [NumMaps*MapW-1:0] blocked;
    logic [NumMaps*MapW-1:0] allowed;
  } maps_t;

  typedef struct packed {
    logic              sys_match;
    logic              blocked_hit;
    logic              allowed_hit;
    logic [CountW-1:0] seen_count;
    logic              overflow;
  } scan_rec_t;

endpackage

>>> hw/rtl/ecf_stream_if.sv
// ----------------------------------------------------------------------------
// ecf_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface ecf_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ecf_front.sv
// ----------------------------------------------------------------------------
// ecf_front
// Byte parser: scans class tags and collects one scan record per message.
// ----------------------------------------------------------------------------
`include "ecm_class_nano_filter_macros.svh"

module ecf_front #(
  parameter int MaxMsgBytes = ecf_pkg::MaxMsgBytesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  ecf_stream_if.sink        in_ch,
  input  ecf_pkg::maps_t    maps,
  input  logic              q_full,
  output logic              push,
  output ecf_pkg::scan_rec_t push_rec
);

  localparam int PosW = $clog2(MaxMsgBytes + 1);
  localparam int SumW = ((PosW > ecf_pkg::ClassW) ? PosW : ecf_pkg::ClassW) + 1;

  typedef enum logic [2:0] {
    M_HEADER,
    M_SEARCH,
    M_LENGTH,
    M_SKIP,
    M_DONE
  } mode_t;

  mode_t                     mode_r, mode_nxt;
  logic [PosW-1:0]           pos_r, pos_nxt;
  logic [PosW-1:0]           cidx_r, cidx_nxt;
  logic                      tps_r, tps_nxt;
  logic                      sys_r, sys_nxt;
  logic [ecf_pkg::CountW-1:0] seen_r, seen_nxt;
  logic                      ahit_r, ahit_nxt;
  logic                      bhit_r, bhit_nxt;
  logic                      ovf_r, ovf_nxt;

  logic                      fire;
  logic [7:0]                b;
  logic                      do_scan;
  logic                      do_judge;
  logic [SumW-1:0]           target;
  logic [PosW-1:0]           start;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data.data_byte;
  assign target      = SumW'(pos_r) + SumW'(b);

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    cidx_nxt = cidx_r;
    tps_nxt  = tps_r;
    seen_nxt = seen_r;
    ahit_nxt = ahit_r;
    bhit_nxt = bhit_r;
    ovf_nxt  = ovf_r;
    do_scan  = 1'b0;
    do_judge = 1'b0;
    start    = tps_r ? PosW'(ecf_pkg::StartTps) : PosW'(ecf_pkg::StartPlain);
    sys_nxt  = (pos_r == '0) ? (in_ch.data.system_id == ecf_pkg::SysFiltered) : sys_r;

    if (pos_r < PosW'(MaxMsgBytes)) begin
      pos_nxt = pos_r + PosW'(1);
      unique case (mode_r)
        M_HEADER: begin
          if (pos_r == PosW'(ecf_pkg::TpsMarkPos)) begin
            tps_nxt = (b == ecf_pkg::MarkTps);
            start   = tps_nxt ? PosW'(ecf_pkg::StartTps) : PosW'(ecf_pkg::StartPlain);
          end
          if (pos_r >= start) begin
            do_scan = 1'b1;
          end
        end
        M_SEARCH: do_scan = 1'b1;
        M_LENGTH: begin
          if (b == '0) begin
            do_judge = 1'b1;
          end else if (target < SumW'(MaxMsgBytes)) begin
            cidx_nxt = target[PosW-1:0];
            mode_nxt = M_SKIP;
          end else begin
            mode_nxt = M_DONE;
          end
        end
        M_SKIP: begin
          if (pos_r == cidx_r) begin
            do_judge = 1'b1;
          end
        end
        default: ;
      endcase

      if (do_judge) begin
        if (seen_r != '1) begin
          seen_nxt = seen_r + ecf_pkg::CountW'(1);
        end
        if (maps.blocked[b]) begin
          bhit_nxt = 1'b1;
          mode_nxt = M_DONE;
        end else begin
          if (maps.allowed[b]) begin
            ahit_nxt = 1'b1;
          end
          do_scan = 1'b1;
        end
      end

      if (do_scan) begin
        priority if (b == ecf_pkg::TagClass) begin
          mode_nxt = M_LENGTH;
        end else if (b == ecf_pkg::MarkStop) begin
          mode_nxt = M_DONE;
        end else begin
          mode_nxt = M_SEARCH;
        end
      end
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign push                 = fire && in_ch.data.last;
  assign push_rec.sys_match   = sys_nxt;
  assign push_rec.blocked_hit = bhit_nxt;
  assign push_rec.allowed_hit = ahit_nxt;
  assign push_rec.seen_count  = seen_nxt;
  assign push_rec.overflow    = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      mode_r <= M_HEADER;
      pos_r  <= '0;
      cidx_r <= '0;
      tps_r  <= 1'b0;
      sys_r  <= 1'b0;
      seen_r <= '0;
      ahit_r <= 1'b0;
      bhit_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      cidx_r <= cidx_nxt;
      tps_r  <= tps_nxt;
      sys_r  <= sys_nxt;
      seen_r <= seen_nxt;
      ahit_r <= ahit_nxt;
      bhit_r <= bhit_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  `ECF_ASSERT(a_pos_bound, (pos_r <= PosW'(MaxMsgBytes)), "byte position past limit")
  `ECF_ASSERT_NEXT(a_last_clears, push, ((pos_r == '0) && (mode_r == M_HEADER)), "message state kept after last byte")

endmodule

>>> hw/rtl/ecf_queue.sv
// ----------------------------------------------------------------------------
// ecf_queue
// Short FIFO of scan records between the parser and the verdict stage.
// ----------------------------------------------------------------------------
`include "ecm_class_nano_filter_macros.svh"

module ecf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ecf_pkg::scan_rec_t push_rec,
  input  logic               pop,
  output ecf_pkg::scan_rec_t head,
  output logic               empty,
  output logic               full
);

  localparam int Depth = ecf_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ecf_pkg::scan_rec_t mem [Depth];
  logic [PtrW-1:0]    wr_ptr_r;
  logic [PtrW-1:0]    rd_ptr_r;
  logic [CntW-1:0]    cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CntW'(Depth));
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CntW'(1);
        2'b01:   cnt_r <= cnt_r - CntW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `ECF_ASSERT(a_cnt_bound, (cnt_r <= CntW'(Depth)), "queue count past depth")
  `ECF_ASSERT(a_no_overrun, (!(push && full && !pop) && !(pop && empty)), "queue over or underrun")

endmodule

>>> hw/rtl/ecf_back.sv
// ----------------------------------------------------------------------------
// ecf_back
// Verdict stage: turns a scan record into the result item and holds it.
// ----------------------------------------------------------------------------
`include "ecm_class_nano_filter_macros.svh"

module ecf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ecf_pkg::maps_t     maps,
  input  ecf_pkg::scan_rec_t head,
  input  logic               q_empty,
  output logic               pop,
  ecf_stream_if.source       out_ch
);

  logic                  out_valid_r;
  ecf_pkg::out_item_t    out_item_r;
  ecf_pkg::out_item_t    item_nxt;
  ecf_pkg::verdict_t     code;
  logic                  blocked_any;
  logic                  allowed_any;

  assign blocked_any = |maps.blocked;
  assign allowed_any = |maps.allowed;
  assign pop         = !q_empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    priority if (!head.sys_match || (!blocked_any && !allowed_any)) begin
      code = ecf_pkg::VC_NA;
    end else if (head.blocked_hit) begin
      code = ecf_pkg::VC_BLOCKED;
    end else if ((head.seen_count != '0) && allowed_any && !head.allowed_hit) begin
      code = ecf_pkg::VC_NO_ALLOWED;
    end else begin
      code = ecf_pkg::VC_OK;
    end
    item_nxt.pass         = (code == ecf_pkg::VC_OK) || (code == ecf_pkg::VC_NA);
    item_nxt.verdict_code = code;
    item_nxt.class_count  = (code == ecf_pkg::VC_NA) ? '0 : head.seen_count;
    item_nxt.overflow     = head.overflow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r <= item_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  `ECF_ASSERT(a_pass_code, (!out_valid_r || (out_item_r.pass == ((out_item_r.verdict_code == ecf_pkg::VC_OK) || (out_item_r.verdict_code == ecf_pkg::VC_NA)))), "pass disagrees with verdict")
  `ECF_ASSERT(a_na_count, (!out_valid_r || (out_item_r.verdict_code != ecf_pkg::VC_NA) || (out_item_r.class_count == '0)), "class count on unchecked message")

endmodule

>>> hw/rtl/ecm_class_nano_filter.sv
// ----------------------------------------------------------------------------
// ecm_class_nano_filter
// Takes one message byte per cycle, back to back, with no gap between messages, while
// the record queue is not full. The last byte's scan record is queued, then popped
// into the registered out_ch item and valid; a 2-entry record queue keeps the parser
// going while a verdict waits. Synchronous reset clears the class maps, message
// state, queue and output valid; bytes are accepted from the first cycle after it.
// ----------------------------------------------------------------------------
module ecm_class_nano_filter #(
  parameter int MaxMsgBytes = ecf_pkg::MaxMsgBytesDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ecf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ecf_pkg::MapW-1:0]     cfg_wdata,
  ecf_stream_if.sink                   in_ch,
  ecf_stream_if.source                 out_ch
);

  ecf_pkg::maps_t     maps_r;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  ecf_pkg::scan_rec_t push_rec;
  ecf_pkg::scan_rec_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maps_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index < ecf_pkg::CfgAllowedBase) begin
        maps_r.blocked[cfg_index[1:0]*ecf_pkg::MapW +: ecf_pkg::MapW] <= cfg_wdata;
      end else begin
        maps_r.allowed[cfg_index[1:0]*ecf_pkg::MapW +: ecf_pkg::MapW] <= cfg_wdata;
      end
    end
  end

  ecf_front #(
    .MaxMsgBytes (MaxMsgBytes)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .maps     (maps_r),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  ecf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ecf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .maps    (maps_r),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
